### rtl/gls1d_pkg.sv
// gls1d_pkg: shared widths, register codes and controller/datapath structs
// for the 1-d gauss-law field solver. no dependencies.
`default_nettype none

package gls1d_pkg;

   localparam int DENSITY_W = 32;
   localparam int FIELD_W   = 48;
   localparam int STEP_W    = 24;
   localparam int NCELLS_W  = 7;
   localparam int FRAC_W    = 16;

   localparam int MAX_CELLS_DEFAULT = 64;
   localparam int MIN_CELLS         = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from address bit 2
   localparam logic REG_GRID_STEP = 1'b0;
   localparam logic REG_N_CELLS   = 1'b1;

   localparam logic [STEP_W-1:0]   GRID_STEP_RESET = 24'd65536;
   localparam logic [NCELLS_W-1:0] N_CELLS_RESET   = 7'd64;

   typedef struct packed {
      logic take_item;
      logic acc_step;
      logic div_start;
      logic div_step;
      logic mean_load;
      logic out_load;
      logic rd_next;
      logic run_clear;
   } gls1d_cmd_type;

   typedef struct packed {
      logic run_end;
      logic div_last;
      logic out_last;
   } gls1d_sts_type;

endpackage

`default_nettype wire

### rtl/gls1d_if.sv
// gls1d_req_if / gls1d_rsp_if: valid/ready channels for density words in
// and field words out. depends on gls1d_pkg.
`default_nettype none

interface gls1d_req_if import gls1d_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DENSITY_W-1:0] density;
   logic                        last_cell;

   modport source (output valid, output density, output last_cell, input ready);
   modport sink   (input valid, input density, input last_cell, output ready);
endinterface

interface gls1d_rsp_if import gls1d_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] field_value;
   logic                      last_field;

   modport source (output valid, output field_value, output last_field, input ready);
   modport sink   (input valid, input field_value, input last_field, output ready);
endinterface

`default_nettype wire

### rtl/gls1d_ram.sv
// gls1d_ram: generic single-write, single-read ram with registered read data.
// no dependencies.
`default_nettype none

module gls1d_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/gls1d_ctrl.sv
// gls1d_ctrl: sequencer for load, accumulate, divide and emit phases.
// depends on gls1d_pkg.
`default_nettype none

module gls1d_ctrl import gls1d_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire gls1d_sts_type sts,
   output gls1d_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;
   localparam logic [2:0] ST_HOLD = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc_step = 1'b1;
            if (sts.run_end) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            // ram address is presented here, data lands next cycle
            cmd.mean_load = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.out_last) begin
                  cmd.run_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/gls1d_dp.sv
// gls1d_dp: field accumulator, run sum, restoring divider for the mean and
// the output stage. depends on gls1d_pkg and gls1d_ram.
`default_nettype none

module gls1d_dp import gls1d_pkg::*; #(
   parameter int MAX_CELLS = MAX_CELLS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire gls1d_cmd_type               cmd,
   output gls1d_sts_type                    sts,
   input  wire logic signed [DENSITY_W-1:0] density,
   input  wire logic                        last_cell,
   input  wire logic [STEP_W-1:0]           grid_step,
   input  wire logic [NCELLS_W-1:0]         eff_cells,
   output logic signed [FIELD_W-1:0]        field_value,
   output logic                             last_field
);

   localparam int IDX_W  = $clog2(MAX_CELLS);
   localparam int CNT_W  = $clog2(MAX_CELLS + 1);
   localparam int SUM_W  = FIELD_W + IDX_W;
   localparam int PROD_W = DENSITY_W + STEP_W + 1;
   localparam int INC_W  = PROD_W - FRAC_W;
   localparam int DCNT_W = $clog2(SUM_W);

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   function automatic logic signed [FIELD_W-1:0] sat_field(
      input logic signed [FIELD_W:0] v
   );
      logic signed [FIELD_W-1:0] r;
      if (v[FIELD_W] != v[FIELD_W-1]) begin
         r = v[FIELD_W] ? FIELD_MIN : FIELD_MAX;
      end else begin
         r = v[FIELD_W-1:0];
      end
      return r;
   endfunction

   // run state
   logic signed [FIELD_W-1:0] running_ff, running_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      end_ff;

   // divider
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              sign_ff;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   // emit
   logic signed [FIELD_W-1:0] mean_ff;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic signed [FIELD_W-1:0] value_ff;
   logic                      last_ff;

   logic signed [STEP_W:0]    step_s;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [INC_W-1:0]   inc;
   logic signed [FIELD_W:0]   acc_wide;
   logic [CNT_W-1:0]          count_next;
   logic                      end_in;
   logic [SUM_W-1:0]          abs_sum;
   logic [CNT_W:0]            rem_sh;
   logic                      q_bit;
   logic signed [FIELD_W-1:0] quot;
   logic signed [FIELD_W-1:0] mean_in;
   logic [FIELD_W-1:0]        rd_data;
   logic signed [FIELD_W:0]   diff_wide;

   gls1d_ram #(
      .WIDTH (FIELD_W),
      .DEPTH (MAX_CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.take_item),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (running_ff),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign step_s     = {1'b0, grid_step};
   assign prod_in    = density * step_s;
   // floor shift of the q24.32 product back to q.16
   assign inc        = INC_W'(prod_ff >>> FRAC_W);
   assign acc_wide   = (FIELD_W+1)'(running_ff) + (FIELD_W+1)'(inc);
   assign count_next = count_ff + CNT_W'(1);
   assign end_in     = last_cell || (NCELLS_W'(count_next) >= eff_cells);

   always_comb begin
      running_in = running_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (cmd.run_clear) begin
         running_in = '0;
         sum_in     = '0;
         count_in   = '0;
      end else begin
         if (cmd.take_item) begin
            sum_in   = sum_ff + SUM_W'(running_ff);
            count_in = count_next;
         end
         if (cmd.acc_step) begin
            running_in = sat_field(acc_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         prod_ff <= prod_in;
         end_ff  <= end_in;
      end
   end

   // restoring divide of |sum| by the cell count, one quotient bit a cycle
   assign abs_sum = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
   assign rem_sh  = {rem_ff, dvd_ff[SUM_W-1]};
   assign q_bit   = rem_sh >= (CNT_W+1)'(count_ff);

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         dvd_in  = abs_sum;
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         dvd_in  = {dvd_ff[SUM_W-2:0], q_bit};
         rem_in  = q_bit ? CNT_W'(rem_sh - (CNT_W+1)'(count_ff)) : CNT_W'(rem_sh);
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      if (cmd.div_start) begin
         sign_ff <= sum_ff[SUM_W-1];
      end
   end

   // mean of a run always fits the field width
   assign quot    = $signed(dvd_ff[FIELD_W-1:0]);
   assign mean_in = sign_ff ? -quot : quot;

   assign diff_wide = (FIELD_W+1)'($signed(rd_data)) - (FIELD_W+1)'(mean_ff);

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.div_start) begin
         rd_idx_in = '0;
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (cmd.mean_load) begin
         mean_ff <= mean_in;
      end
      if (cmd.out_load) begin
         value_ff <= sat_field(diff_wide);
         last_ff  <= (rd_idx_ff + CNT_W'(1)) == count_ff;
      end
   end

   assign sts.run_end  = end_ff;
   assign sts.div_last = dcnt_ff == DCNT_W'(SUM_W - 1);
   assign sts.out_last = last_ff;

   assign field_value = value_ff;
   assign last_field  = last_ff;

endmodule

`default_nettype wire

### rtl/gauss_law_field_solve_1d_core.sv
// gauss_law_field_solve_1d_core: top level with csr registers, controller and
// datapath. depends on gls1d_pkg, gls1d_if, gls1d_ctrl, gls1d_dp, gls1d_ram.
//
//  channel   | dir | word                       | handshake
//  ----------+-----+----------------------------+-----------------------------
//  req_chan  | in  | density, last_cell         | valid/ready
//  rsp_chan  | out | field_value, last_field    | valid/ready
//  csr_*     | in  | grid_step @0, n_cells @4   | apb write, pready tied high
//
// each density is accepted (store write, sum, multiply), then its field is
// accumulated before the next is taken. the end of a run runs the bit-serial
// mean divider, then each result passes the store's registered read and the
// output register and waits out any rsp stall.
// reset is synchronous and clears the run; the field store is not cleared.
// no density is taken while a run's results are being emitted.
`default_nettype none

module gauss_law_field_solve_1d_core import gls1d_pkg::*; #(
   parameter int MAX_CELLS = MAX_CELLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gls1d_req_if.sink                  req_chan,
   gls1d_rsp_if.source                rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [STEP_W-1:0]   grid_step_ff;
   logic [NCELLS_W-1:0] n_cells_ff;
   logic [NCELLS_W-1:0] eff_cells;
   logic                csr_write;

   gls1d_cmd_type cmd;
   gls1d_sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_step_ff <= GRID_STEP_RESET;
         n_cells_ff   <= N_CELLS_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_GRID_STEP: grid_step_ff <= csr_pwdata[STEP_W-1:0];
            REG_N_CELLS:   n_cells_ff   <= csr_pwdata[NCELLS_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GRID_STEP: csr_prdata = CSR_DATA_W'(grid_step_ff);
         REG_N_CELLS:   csr_prdata = CSR_DATA_W'(n_cells_ff);
      endcase
   end

   always_comb begin
      if (n_cells_ff < NCELLS_W'(MIN_CELLS)) begin
         eff_cells = NCELLS_W'(MIN_CELLS);
      end else if (n_cells_ff > NCELLS_W'(MAX_CELLS)) begin
         eff_cells = NCELLS_W'(MAX_CELLS);
      end else begin
         eff_cells = n_cells_ff;
      end
   end

   gls1d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gls1d_dp #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .density     (req_chan.density),
      .last_cell   (req_chan.last_cell),
      .grid_step   (grid_step_ff),
      .eff_cells   (eff_cells),
      .field_value (rsp_chan.field_value),
      .last_field  (rsp_chan.last_field)
   );

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while a result is offered");

   // every density needs its accumulate step before the next one
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input accepted in back-to-back cycles");

   // the final word of a run returns the block to loading
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_field) |=> req_chan.ready)
      else $error("not ready for a new run after the final word");

endmodule

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking bench for gauss_law_field_solve_1d_core, a directed table then random
// density runs checked against an in-bench field solver. depends on gls1d_pkg, gls1d_if, rtl.
`timescale 1ns / 1ps

module tb_top;
   import gls1d_pkg::*;

   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  RANDOM_ITEMS = 205;
   localparam int  CALM_ITEMS   = 40;
   localparam int  SETTLE       = 8;
   localparam int  DRAIN        = 120;
   localparam int  N_ROWS       = 25;
   localparam int  GRID_CELLS   = 64;
   localparam longint FIELD_MAX = (64'sd1 <<< (FIELD_W - 1)) - 1;
   localparam longint FIELD_MIN = -FIELD_MAX - 1;

   typedef struct {
      logic signed [FIELD_W-1:0] value;
      logic                      last;
   } field_word_type;

   typedef enum logic {ROW_WRITE, ROW_CELL} row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic                        reg_idx;
      logic [CSR_DATA_W-1:0]       reg_value;
      logic signed [DENSITY_W-1:0] density;
      logic                        last;
      logic                        typed;
      logic signed [FIELD_W-1:0]   field;
   } cell_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gls1d_req_if req_if ();
   gls1d_rsp_if rsp_if ();

   gauss_law_field_solve_1d_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // solver state and register copies
   logic [STEP_W-1:0]   step_cfg;
   logic [NCELLS_W-1:0] cells_cfg;
   longint              field_mem [GRID_CELLS];
   longint              field_run;
   longint              field_total;
   int                  cells_taken;

   field_word_type pending_fields [$];
   cell_row_type   directed_rows [N_ROWS];
   int             errors;
   int             cycles;
   int             rsp_hold;
   bit             idle_on;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint clamp_field(input longint v);
      if (v > FIELD_MAX) return FIELD_MAX;
      if (v < FIELD_MIN) return FIELD_MIN;
      return v;
   endfunction

   // takes one density, queues the run's field words when the run closes
   function automatic void solve_cell(input logic signed [DENSITY_W-1:0] dens, input logic last);
      longint step;
      longint prod;
      longint mean;
      int     idx;
      int     span;
      step = longint'(step_cfg);
      prod = longint'(dens) * step;
      idx  = (cells_taken >= GRID_CELLS) ? GRID_CELLS - 1 : cells_taken;
      field_mem[idx] = field_run;
      field_total   += field_run;
      field_run      = clamp_field(field_run + (prod >>> FRAC_W));
      cells_taken    = idx + 1;
      span = (cells_cfg < MIN_CELLS) ? MIN_CELLS : cells_cfg;
      if (span > GRID_CELLS) span = GRID_CELLS;
      if (!last && cells_taken < span) return;
      mean = field_total / longint'(cells_taken);
      for (int i = 0; i < cells_taken; i++) begin
         pending_fields.push_back('{clamp_field(field_mem[i] - mean), i == cells_taken - 1});
      end
      field_run   = 0;
      field_total = 0;
      cells_taken = 0;
   endfunction

   // output side: checks each accepted field word and stalls ready in bursts
   always @(posedge clock) begin : field_check
      field_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_fields.size() == 0) begin
            $error("field word %0d with nothing expected", rsp_if.field_value);
            errors++;
         end else begin
            want = pending_fields.pop_front();
            if (rsp_if.field_value !== want.value) begin
               $error("field_value expected %0d got %0d", want.value, rsp_if.field_value);
               errors++;
            end
            if (rsp_if.last_field !== want.last) begin
               $error("last_field expected %0b got %0b", want.last, rsp_if.last_field);
               errors++;
            end
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(0, 2);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic csr_write(input logic reg_idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_idx == REG_GRID_STEP) step_cfg = value[STEP_W-1:0];
      else cells_cfg = value[NCELLS_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // drops valid, waits for every expected word, then lets the block settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_density(input logic signed [DENSITY_W-1:0] dens, input logic last,
                               input logic typed, input logic signed [FIELD_W-1:0] field);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.density   <= dens;
      req_if.last_cell <= last;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      solve_cell(dens, last);
      if (typed) begin
         void'(pending_fields.pop_back());
         pending_fields.push_back('{field, 1'b1});
      end
   endtask

   function automatic logic [DENSITY_W-1:0] rand_density();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_step();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 24'hFF_FFFF;
         2: return 24'h01_0000;
         3: return $urandom_range(0, 24'h04_0000);
         default: return $urandom & 24'hFF_FFFF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_cells();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 127;
         3: return $urandom_range(0, 127);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   task automatic load_rows();
      directed_rows = '{
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h7FFF_FFFF, 1'b1, 1'b1, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h8000_0000, 1'b1, 1'b1, 0},
         // n_cells below the floor acts as two
         '{ROW_WRITE, REG_N_CELLS,   0,          0,             1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h7FFF_FFFF, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h8000_0000, 1'b0, 1'b0, 0},
         '{ROW_WRITE, REG_GRID_STEP, 24'hFF_FFFF, 0,            1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h8000_0000, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h7FFF_FFFF, 1'b0, 1'b0, 0},
         '{ROW_WRITE, REG_N_CELLS,   1,          0,             1'b0, 1'b0, 0},
         '{ROW_WRITE, REG_GRID_STEP, 0,          0,             1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h1234_5678, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'hFFFF_FFFF, 1'b0, 1'b0, 0},
         // n_cells above the ceiling acts as 64, run closed early by last_cell
         '{ROW_WRITE, REG_GRID_STEP, 24'h01_0000, 0,            1'b0, 1'b0, 0},
         '{ROW_WRITE, REG_N_CELLS,   127,        0,             1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h0005_0000, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'hFFF9_0000, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h0009_0000, 1'b1, 1'b0, 0},
         // n_cells lowered below the cell count in the middle of a run
         '{ROW_WRITE, REG_N_CELLS,   10,         0,             1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h0001_0000, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h0002_0000, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'hFFFF_0000, 1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h0000_8000, 1'b0, 1'b0, 0},
         '{ROW_WRITE, REG_N_CELLS,   3,          0,             1'b0, 1'b0, 0},
         '{ROW_CELL,  REG_GRID_STEP, 0,          32'h0003_0000, 1'b0, 1'b0, 0},
         '{ROW_WRITE, REG_N_CELLS,   2,          0,             1'b0, 1'b0, 0}
      };
   endtask

   initial begin : stimulus
      int cells_sent;
      int phase;
      int burst;
      int last_odds;
      logic last;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_if.valid     = 1'b0;
      req_if.density   = '0;
      req_if.last_cell = 1'b0;
      rsp_if.ready     = 1'b1;
      errors      = 0;
      cycles      = 0;
      rsp_hold    = 0;
      idle_on     = 1'b1;
      step_cfg    = GRID_STEP_RESET;
      cells_cfg   = N_CELLS_RESET;
      field_run   = 0;
      field_total = 0;
      cells_taken = 0;
      load_rows();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            wait_idle();
            csr_write(directed_rows[r].reg_idx, directed_rows[r].reg_value);
         end else begin
            send_density(directed_rows[r].density, directed_rows[r].last,
                         directed_rows[r].typed, directed_rows[r].field);
         end
      end

      cells_sent = 0;
      phase      = 0;
      while (cells_sent < RANDOM_ITEMS) begin
         idle_on = (cells_sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         wait_idle();
         csr_write(REG_GRID_STEP, rand_step());
         // one phase sends 64 cells with n_cells at 64 and no last_cell
         if (phase == 3) begin
            csr_write(REG_N_CELLS, GRID_CELLS);
            burst     = GRID_CELLS;
            last_odds = 0;
         end else begin
            csr_write(REG_N_CELLS, rand_cells());
            burst     = $urandom_range(4, 24);
            last_odds = $urandom_range(0, 8);
         end
         for (int i = 0; i < burst; i++) begin
            if (cells_sent >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            last = (last_odds != 0) && ($urandom_range(1, last_odds) == 1);
            send_density(rand_density(), last, 1'b0, 0);
            cells_sent++;
         end
         phase++;
      end
      // close whatever run is open so every word gets checked
      send_density(rand_density(), 1'b1, 1'b0, 0);
      req_if.valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/gls1d_pkg.sv
rtl/gls1d_if.sv
rtl/gls1d_ram.sv
rtl/gls1d_ctrl.sv
rtl/gls1d_dp.sv
rtl/gauss_law_field_solve_1d_core.sv
dv/tb_top.sv
